/* rtl/core/rgt_pkg.sv */
// Shared types and constants for the revision gap tracker.
// Used by every module under rtl/core except rgt_ram; depends on nothing else.
package rgt_pkg;

  // Slot table geometry.
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int SLOT_W     = 6;
  localparam int REV_W      = 64;

  // One table record: terminal flag, resync flag and last applied revision.
  localparam int REC_W = REV_W + 2;

  // Depth of the queue between the classifier and the executor.
  localparam int QUEUE_DEPTH = 2;

  // Stream widths, rounded up to whole bytes.
  localparam int IN_BITS    = SLOT_W + 3 + 3 * REV_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_BITS   = 3 + 3 + REV_W + 3 + REV_W + REV_W + 1 + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_SNAPSHOT  = 2'd0,
    MODE_TOMBSTONE = 2'd1,
    MODE_DELTA     = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_INVALID  = 3'd2,
    ST_SNAP_REQ = 3'd3,
    ST_ID_REJ   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    DG_NONE       = 3'd0,
    DG_DUP        = 3'd1,
    DG_RANGE      = 3'd2,
    DG_GAP        = 3'd3,
    DG_IMPOSSIBLE = 3'd4
  } diag_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SNAPSHOT = 3'd1,
    EV_TOMB     = 3'd2,
    EV_APPLIED  = 3'd3,
    EV_RESYNC   = 3'd4
  } event_t;

  // Classification made by the front end.
  typedef enum logic [2:0] {
    K_SNAP,     // accepted snapshot
    K_TOMB,     // accepted tombstone
    K_DELTA,    // consistent delta, judged against the record
    K_IDREJ,    // identifier rejected
    K_BADARG,   // bad mode or inconsistent delta on a valid slot
    K_BADSLOT   // slot outside the table
  } kind_t;

  // Classified item carried through the queue. For snapshots and tombstones
  // rev is the carried revision, for deltas the successor revision, and for
  // rejected items the detail value to report.
  typedef struct packed {
    kind_t              kind;
    logic [SLOT_AW-1:0] idx;
    logic               to_term;
    logic [REV_W-1:0]   prior;
    logic [REV_W-1:0]   rev;
  } item_t;

  typedef struct packed {
    status_t          status;
    diag_t            diagnostic;
    logic [REV_W-1:0] detail;
    event_t           event_res;
    logic [REV_W-1:0] event_revision;
    logic [REV_W-1:0] applied_revision;
    logic             resync_pending;
    logic             is_terminal;
  } result_t;

endpackage

/* rtl/core/revision_gap_tracker_core.sv */
// Top level of the revision gap tracker: front end, item queue, back end.
// Depends on rgt_pkg, rgt_front, rgt_queue, rgt_back and rgt_ram.
//
//  Channel   Direction  Handshake                      Content
//  s_axis    in         s_axis_tvalid / s_axis_tready  one request beat, mode in tuser
//  m_axis    out        m_axis_tvalid / m_axis_tready  one result beat per request
//
// The back end first reads the slot record from the table RAM, then, once the
// output register is free, judges it, writes it back and loads the output register.
// The front end classifies a beat in the cycle it arrives and queues up to two
// beats, so input and output stall independently.
// Reset is synchronous; per-slot written marks make the table read as cleared at
// once, with no clearing pass.
module revision_gap_tracker_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // slot, id_ok, to_terminal, has_terminal_record, payload_revision,
  // prior_revision, next_revision, zero fill
  input  logic [rgt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [rgt_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status, diagnostic, detail, event_res, event_revision, applied_revision,
  // resync_pending, is_terminal, zero fill
  output logic [rgt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic             push_valid;
  logic             push_ready;
  rgt_pkg::item_t   push_item;
  logic             pop_valid;
  logic             pop_ready;
  rgt_pkg::item_t   pop_item;
  rgt_pkg::result_t res;

  rgt_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_user    (s_axis_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rgt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  rgt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_pop     (pop_ready),
    .q_item    (pop_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack the result beat, first field in the lowest bits.
  assign m_axis_tdata = {
    (rgt_pkg::OUT_DATA_W - rgt_pkg::OUT_BITS)'(0),
    res.is_terminal,
    res.resync_pending,
    res.applied_revision,
    res.event_revision,
    res.event_res,
    res.detail,
    res.diagnostic,
    res.status
  };

endmodule

/* rtl/core/rgt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module rgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/rgt_front.sv */
// Front end: unpacks an input beat and classifies it into a queue item.
// Depends on rgt_pkg.
module rgt_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rgt_pkg::IN_DATA_W-1:0] in_data,
  input  logic [rgt_pkg::IN_USER_W-1:0] in_user,
  output logic                          push_valid,
  input  logic                          push_ready,
  output rgt_pkg::item_t                push_item
);

  rgt_pkg::mode_t                   mode;
  logic [rgt_pkg::SLOT_W-1:0]       slot;
  logic                             id_ok;
  logic                             to_term;
  logic                             has_rec;
  logic [rgt_pkg::REV_W-1:0]        pay;
  logic [rgt_pkg::REV_W-1:0]        prior;
  logic [rgt_pkg::REV_W-1:0]        next_rev;
  logic                             slot_ok;

  // Field unpacking, first field in the lowest bits.
  assign mode     = rgt_pkg::mode_t'(in_user);
  assign slot     = in_data[5:0];
  assign id_ok    = in_data[6];
  assign to_term  = in_data[7];
  assign has_rec  = in_data[8];
  assign pay      = in_data[72:9];
  assign prior    = in_data[136:73];
  assign next_rev = in_data[200:137];
  assign slot_ok  = 32'(slot) < rgt_pkg::SLOT_COUNT;

  // The queue takes a beat whenever it has room.
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // Classification: everything that does not need the slot record.
  always_comb begin
    push_item.idx     = rgt_pkg::SLOT_AW'(slot);
    push_item.to_term = to_term;
    push_item.prior   = prior;
    push_item.kind    = rgt_pkg::K_BADARG;
    push_item.rev     = '0;
    case (mode)
      rgt_pkg::MODE_SNAPSHOT, rgt_pkg::MODE_TOMBSTONE: begin
        if (!id_ok) begin
          push_item.kind = rgt_pkg::K_IDREJ;
        end else begin
          push_item.kind = (mode == rgt_pkg::MODE_TOMBSTONE) ? rgt_pkg::K_TOMB
                                                             : rgt_pkg::K_SNAP;
          push_item.rev  = pay;
        end
      end
      rgt_pkg::MODE_DELTA: begin
        if (to_term && (!has_rec || pay != next_rev)) begin
          push_item.kind = rgt_pkg::K_BADARG;
          push_item.rev  = next_rev;
        end else if (!to_term && pay != next_rev) begin
          push_item.kind = rgt_pkg::K_BADARG;
          push_item.rev  = pay;
        end else begin
          push_item.kind = rgt_pkg::K_DELTA;
          push_item.rev  = next_rev;
        end
      end
      default: begin
        push_item.kind = rgt_pkg::K_BADARG;
        push_item.rev  = '0;
      end
    endcase
    // A slot outside the table overrides every other outcome.
    if (!slot_ok) begin
      push_item.kind = rgt_pkg::K_BADSLOT;
      push_item.rev  = '0;
    end
  end

endmodule

/* rtl/core/rgt_queue.sv */
// Short FIFO of classified items between the front end and the executor.
// Depends on rgt_pkg.
module rgt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rgt_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rgt_pkg::item_t pop_item
);

  localparam int PTR_W = (rgt_pkg::QUEUE_DEPTH > 1) ? $clog2(rgt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rgt_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rgt_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rgt_pkg::QUEUE_DEPTH);

  rgt_pkg::item_t   entries [rgt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Item storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/rgt_back.sv */
// Back end: reads the slot record, judges the item, writes the record back
// and holds the result beat. Depends on rgt_pkg and rgt_ram.
module rgt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  rgt_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output rgt_pkg::result_t out_res
);

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } state_t;

  state_t                          state;
  rgt_pkg::item_t                  held;
  logic [rgt_pkg::SLOT_COUNT-1:0]  filled;
  logic [rgt_pkg::REC_W-1:0]       rd_rec;
  logic [rgt_pkg::REC_W-1:0]       wr_rec;
  logic                            wr_need;
  logic                            commit;
  logic                            ram_we;
  logic [rgt_pkg::REV_W-1:0]       cur;
  logic                            cur_resync;
  logic                            cur_term;
  logic [rgt_pkg::REV_W-1:0]       rec_rev_next;
  logic                            rec_resync_next;
  logic                            rec_term_next;
  rgt_pkg::result_t                res_next;

  // Record table: {terminal, resync, last revision} per slot.
  rgt_ram #(
    .WIDTH (rgt_pkg::REC_W),
    .DEPTH (rgt_pkg::SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (held.idx),
    .wdata (wr_rec),
    .re    (q_pop),
    .raddr (q_item.idx),
    .rdata (rd_rec)
  );

  // Take an item only while idle; commit once the output register is free.
  assign q_pop  = (state == B_IDLE) && q_valid;
  assign commit = (state == B_EXEC) && (!out_valid || out_ready);
  assign ram_we = commit && wr_need;
  assign wr_rec = {rec_term_next, rec_resync_next, rec_rev_next};

  // A slot never written reads as the cleared record.
  always_comb begin
    if (filled[held.idx]) begin
      cur        = rd_rec[rgt_pkg::REV_W-1:0];
      cur_resync = rd_rec[rgt_pkg::REV_W];
      cur_term   = rd_rec[rgt_pkg::REV_W+1];
    end else begin
      cur        = '0;
      cur_resync = 1'b0;
      cur_term   = 1'b0;
    end
  end

  // Judge the item against the current record.
  always_comb begin
    rec_rev_next    = cur;
    rec_resync_next = cur_resync;
    rec_term_next   = cur_term;
    wr_need         = 1'b0;
    res_next.status         = rgt_pkg::ST_OK;
    res_next.diagnostic     = rgt_pkg::DG_NONE;
    res_next.detail         = '0;
    res_next.event_res      = rgt_pkg::EV_NONE;
    res_next.event_revision = '0;
    case (held.kind)
      rgt_pkg::K_SNAP, rgt_pkg::K_TOMB: begin
        rec_rev_next            = held.rev;
        rec_resync_next         = 1'b0;
        rec_term_next           = (held.kind == rgt_pkg::K_TOMB);
        wr_need                 = 1'b1;
        res_next.event_res      = (held.kind == rgt_pkg::K_TOMB) ? rgt_pkg::EV_TOMB
                                                                 : rgt_pkg::EV_SNAPSHOT;
        res_next.event_revision = held.rev;
      end
      rgt_pkg::K_DELTA: begin
        if (held.rev <= cur) begin
          res_next.status     = rgt_pkg::ST_DUP;
          res_next.diagnostic = rgt_pkg::DG_DUP;
          res_next.detail     = held.rev;
        end else if (cur_resync) begin
          res_next.status     = rgt_pkg::ST_SNAP_REQ;
          res_next.diagnostic = rgt_pkg::DG_GAP;
          res_next.detail     = held.prior;
        end else if (held.prior == cur) begin
          // In-order delta: apply it.
          rec_rev_next            = held.rev;
          rec_resync_next         = 1'b0;
          rec_term_next           = held.to_term;
          wr_need                 = 1'b1;
          res_next.event_res      = held.to_term ? rgt_pkg::EV_TOMB : rgt_pkg::EV_APPLIED;
          res_next.event_revision = held.rev;
        end else begin
          // Gap when the predecessor is ahead, impossible when it is behind.
          rec_resync_next         = 1'b1;
          wr_need                 = 1'b1;
          res_next.status         = rgt_pkg::ST_SNAP_REQ;
          res_next.diagnostic     = (held.prior > cur) ? rgt_pkg::DG_GAP
                                                       : rgt_pkg::DG_IMPOSSIBLE;
          res_next.detail         = held.prior;
          res_next.event_res      = rgt_pkg::EV_RESYNC;
          res_next.event_revision = cur;
        end
      end
      rgt_pkg::K_IDREJ: begin
        res_next.status = rgt_pkg::ST_ID_REJ;
      end
      rgt_pkg::K_BADARG, rgt_pkg::K_BADSLOT: begin
        res_next.status     = rgt_pkg::ST_INVALID;
        res_next.diagnostic = rgt_pkg::DG_RANGE;
        res_next.detail     = held.rev;
      end
      default: begin
        res_next.status     = rgt_pkg::ST_INVALID;
        res_next.diagnostic = rgt_pkg::DG_RANGE;
      end
    endcase
    // Record after the step; a slot outside the table reports zeros.
    if (held.kind == rgt_pkg::K_BADSLOT) begin
      res_next.applied_revision = '0;
      res_next.resync_pending   = 1'b0;
      res_next.is_terminal      = 1'b0;
    end else begin
      res_next.applied_revision = rec_rev_next;
      res_next.resync_pending   = rec_resync_next;
      res_next.is_terminal      = rec_term_next;
    end
  end

  // Sequencer, held item, written-slot marks and output register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      held <= q_item;
    end
    if (commit) begin
      out_res <= res_next;
    end
    if (rst) begin
      state     <= B_IDLE;
      filled    <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            state <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (commit) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (ram_we) begin
        filled[held.idx] <= 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
